// ----- rtl/sat_pkg.sv -----
// Shared types, field widths and codes for the sorted array table.
`timescale 1ns / 1ps

package sat_pkg;

   // Default sizing of the table
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Field widths on the stream channels
   localparam int OP_W       = 2;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 4;
   localparam int READ_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Read address selection
   typedef enum logic [2:0] {
      RD_TOP   = 3'd0,
      RD_WALK  = 3'd1,
      RD_IDX   = 3'd2,
      RD_IDX1  = 3'd3,
      RD_SHIFT = 3'd4
   } rd_sel_type;

   // Write data selection
   typedef enum logic {
      WR_DATA  = 1'b0,
      WR_VALUE = 1'b1
   } wr_sel_type;

   // Pointer update
   typedef enum logic [2:0] {
      PTR_HOLD       = 3'd0,
      PTR_LOAD_COUNT = 3'd1,
      PTR_LOAD_IDX   = 3'd2,
      PTR_DEC        = 3'd3,
      PTR_INC        = 3'd4
   } ptr_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      ptr_op_type ptr_op;
      logic       set_status;
      status_type status;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       latch_read;
      logic       load_rsp;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   cnt_zero;
      logic   idx_ok;
      logic   has_shift;
      logic   walk_lt;
      logic   walk_last;
      logic   shift_last;
      logic   out_free;
   } stat_type;

endpackage

// ----- rtl/sat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic                                re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/sat_datapath.sv -----
// Datapath of the sorted array table: request registers, entry memory, count and response.
`timescale 1ns / 1ps

module sat_datapath #(
   parameter int CAPACITY    = sat_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sat_pkg::op_type               req_op,
   input  logic [sat_pkg::VALUE_W-1:0]   req_value,
   input  logic [sat_pkg::INDEX_W-1:0]   req_index,
   input  sat_pkg::cmd_type              cmd,
   output sat_pkg::stat_type             stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sat_pkg::READ_W-1:0]    rsp_read_value,
   output sat_pkg::status_type           rsp_status,
   output logic [sat_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import sat_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + INDEX_W;

   op_type                 op_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [INDEX_W-1:0]     idx_ff;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          count_ff, count_in;
   status_type             status_ff;
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic                   rsp_valid_ff;
   logic [READ_W-1:0]      rsp_value_ff;
   status_type             rsp_status_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   logic [AW-1:0]          raddr, waddr;
   logic [VALUE_WIDTH-1:0] wdata, rdata;
   logic [XW-1:0]          idx_x, cnt_x, idx1_x;
   logic [CW:0]            ptr2;

   // Entry storage
   sat_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Derived index and pointer values
   assign idx_x  = XW'(idx_ff);
   assign cnt_x  = XW'(count_ff);
   assign idx1_x = idx_x + XW'(1);
   assign ptr2   = {1'b0, ptr_ff} + (CW + 1)'(2);

   // Status toward the controller
   assign stat.op         = op_ff;
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.cnt_zero   = (count_ff == '0);
   assign stat.idx_ok     = (idx_x < cnt_x);
   assign stat.has_shift  = (idx1_x < cnt_x);
   assign stat.walk_lt    = (rdata < value_ff);
   assign stat.walk_last  = (ptr_ff == CW'(1));
   assign stat.shift_last = (ptr2 >= {1'b0, count_ff});
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Select read address
   always_comb begin
      case (cmd.rd_sel)
         RD_TOP:   raddr = AW'(count_ff - CW'(1));
         RD_WALK:  raddr = AW'(ptr_ff - CW'(2));
         RD_IDX:   raddr = AW'(idx_x);
         RD_IDX1:  raddr = AW'(idx1_x);
         RD_SHIFT: raddr = AW'(ptr2);
         default:  raddr = '0;
      endcase
   end

   // Write goes to the pointer, carrying either the new value or a moved entry
   assign waddr = AW'(ptr_ff);
   assign wdata = (cmd.wr_sel == WR_VALUE) ? value_ff : rdata;

   // Pointer update
   always_comb begin
      case (cmd.ptr_op)
         PTR_LOAD_COUNT: ptr_in = count_ff;
         PTR_LOAD_IDX:   ptr_in = CW'(idx_x);
         PTR_DEC:        ptr_in = ptr_ff - CW'(1);
         PTR_INC:        ptr_in = ptr_ff + CW'(1);
         default:        ptr_in = ptr_ff;
      endcase
   end

   // Count update
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture request, status and lookup data
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         value_ff <= VALUE_WIDTH'(req_value);
         idx_ff   <= req_index;
         rd_ff    <= '0;
      end else if (cmd.latch_read) begin
         rd_ff <= rdata;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_value_ff  <= READ_W'(rd_ff);
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Checks on the table bookkeeping
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff != CW'(CAPACITY)) && !cmd.cnt_dec)
      else $error("insert completed on a full table");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> (count_ff != '0))
      else $error("remove completed on an empty table");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (waddr != raddr))
      else $error("read and write hit the same entry");

endmodule

// ----- rtl/sat_controller.sv -----
// Controller state machine of the sorted array table.
`timescale 1ns / 1ps

module sat_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sat_pkg::stat_type stat,
   output sat_pkg::cmd_type  cmd
);
   import sat_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_WALK   = 7'b0000100,
      S_PLACE  = 7'b0001000,
      S_LOOK   = 7'b0010000,
      S_SHIFT  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_TOP;
      cmd.wr_sel     = WR_DATA;
      cmd.ptr_op     = PTR_HOLD;
      cmd.status     = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                     state_in   = S_RESP;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_COUNT;
                     if (stat.cnt_zero) begin
                        state_in = S_PLACE;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TOP;
                        state_in   = S_WALK;
                     end
                  end
               end
               OP_LOOKUP: begin
                  if (stat.idx_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX;
                     state_in   = S_LOOK;
                  end else begin
                     cmd.status = ST_RANGE;
                     state_in   = S_RESP;
                  end
               end
               OP_REMOVE: begin
                  if (!stat.idx_ok) begin
                     cmd.status = ST_RANGE;
                     state_in   = S_RESP;
                  end else if (stat.has_shift) begin
                     cmd.ptr_op = PTR_LOAD_IDX;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX1;
                     state_in   = S_SHIFT;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_RESP;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            // Move entries not below the value up, place it over the first smaller one
            cmd.wr_en = 1'b1;
            if (stat.walk_lt) begin
               cmd.wr_sel  = WR_VALUE;
               cmd.cnt_inc = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.wr_sel = WR_DATA;
               cmd.ptr_op = PTR_DEC;
               if (stat.walk_last) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_WALK;
               end
            end
         end
         S_PLACE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_VALUE;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_LOOK: begin
            cmd.latch_read = 1'b1;
            state_in       = S_RESP;
         end
         S_SHIFT: begin
            // Move the next entry down over the removed slot
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DATA;
            cmd.ptr_op = PTR_INC;
            if (stat.shift_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SHIFT;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks on sequencing
   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted transaction not decoded");

   a_rsp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (state_ff == S_IDLE))
      else $error("response loaded without returning to idle");

   a_one_write_src: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (state_ff == S_WALK || state_ff == S_PLACE || state_ff == S_SHIFT))
      else $error("memory write outside a walk, place or shift");

endmodule

// ----- rtl/sorted_array_table.sv -----
// Top level of the sorted array table.
`timescale 1ns / 1ps
//
// Keeps up to CAPACITY unsigned values in ascending order in a RAM.
// Request channel (req_*): one transaction carries an operation in tuser
// (insert, lookup at index, remove at index, nop), value and index in tdata.
// Response channel (rsp_*): one transaction per request with the looked-up
// value (zero unless a good lookup), a status code and the entry count.
// The insert walk and the remove shift move one entry per cycle through the
// single read and single write port of the entry RAM.
// A new request is taken once the previous response is in the output
// register, so a response waiting on rsp_tready does not block the next
// request; the following response then waits until the register is free.
// Reset empties the table and drops any pending response; entry contents are
// not cleared and need no clearing pass.
//
module sorted_array_table #(
   parameter int CAPACITY    = sat_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // value [31:0], index [35:32], zero [39:36]
   input  logic [sat_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op [1:0]
   input  logic [sat_pkg::OP_W-1:0]         req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], entry_count [36:32], zero [39:37]
   output logic [sat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [sat_pkg::STATUS_W-1:0]     rsp_tuser
);
   import sat_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [READ_W-1:0]   rsp_read_value;
   status_type          rsp_status;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // Sequencer
   sat_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and response
   sat_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (op_type'(req_tuser)),
      .req_value       (req_tdata[VALUE_W-1:0]),
      .req_index       (req_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Pack response payload
   assign rsp_tdata = {(RSP_DATA_W - READ_W - COUNT_W)'(0), rsp_entry_count, rsp_read_value};
   assign rsp_tuser = rsp_status;

endmodule

// ----- tb/sv/sorted_array_table_tb.sv -----
// Self-checking testbench for the sorted array table: directed rows, then random traffic.
`timescale 1ns / 1ps
module sorted_array_table_tb;
   import sat_pkg::*;

   localparam int CAP          = CAPACITY_DEF;
   localparam int RANDOM_OPS   = 1900;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_ROWS     = 26;

   typedef struct packed {
      logic [READ_W-1:0]  read_value;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
   } table_rsp_type;

   typedef struct packed {
      op_type              op;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  index;
      logic                typed;
      table_rsp_type       rsp;
   } stim_row_type;

   localparam table_rsp_type NO_RSP = '0;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // value [31:0], index [35:32], zero [39:36]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // op [1:0]
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // read_value [31:0], entry_count [36:32], zero [39:37]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]   rsp_tuser;

   // Shadow copy of the sorted entries and the count
   logic [VALUE_W-1:0] shadow_vals [CAP];
   int                 shadow_count = 0;
   table_rsp_type      pending_rsps [$];
   stim_row_type       stim_rows [NUM_ROWS];
   int                 error_count = 0;
   int                 cycle_count = 0;
   bit                 no_idle = 1'b0;

   sorted_array_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one operation to the shadow table and return the response it gives
   function automatic table_rsp_type predict_table_op(input op_type op,
                                                      input logic [VALUE_W-1:0] value,
                                                      input logic [INDEX_W-1:0] index);
      table_rsp_type r;
      int            pos;
      int            k;
      r = NO_RSP;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               // walk past smaller entries, then open a slot
               pos = 0;
               while (pos < shadow_count && shadow_vals[pos] < value) pos++;
               for (k = shadow_count; k > pos; k--) shadow_vals[k] = shadow_vals[k - 1];
               shadow_vals[pos] = value;
               shadow_count++;
            end
         end
         OP_LOOKUP: begin
            if (index < shadow_count) r.read_value = shadow_vals[index];
            else r.status = ST_RANGE;
         end
         OP_REMOVE: begin
            if (index < shadow_count) begin
               for (k = index; k + 1 < shadow_count; k++) shadow_vals[k] = shadow_vals[k + 1];
               shadow_count--;
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Drive one request transaction from a falling edge, record its response on acceptance
   task automatic send_op(input op_type op, input logic [VALUE_W-1:0] value,
                          input logic [INDEX_W-1:0] index, input logic typed,
                          input table_rsp_type typed_rsp);
      table_rsp_type predicted;
      int            gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - VALUE_W - INDEX_W){1'b0}}, index, value};
      do @(posedge clock); while (!req_tready);
      predicted = predict_table_op(op, value, index);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stimulus: directed rows, then random phases
   initial begin
      int           i;
      int           j;
      int           done;
      int           phase_len;
      int           insert_pct;
      bit           first_phase;
      op_type       op;
      logic [31:0]  v;
      logic [3:0]   ix;

      // Empty table, extremes, fill to capacity, refusals, drain from both ends
      stim_rows[0]  = '{OP_LOOKUP, 32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_RANGE, 5'd0}};
      stim_rows[1]  = '{OP_REMOVE, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_RANGE, 5'd0}};
      stim_rows[2]  = '{OP_NOP,    32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_OK, 5'd0}};
      stim_rows[3]  = '{OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, ST_OK, 5'd1}};
      stim_rows[4]  = '{OP_INSERT, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_OK, 5'd2}};
      stim_rows[5]  = '{OP_LOOKUP, 32'h0000_0000, 4'd1,  1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd2}};
      stim_rows[6]  = '{OP_LOOKUP, 32'h0000_0000, 4'd2,  1'b1, '{32'h0, ST_RANGE, 5'd2}};
      stim_rows[7]  = '{OP_INSERT, 32'h8000_0000, 4'd0,  1'b0, NO_RSP};
      stim_rows[8]  = '{OP_INSERT, 32'h8000_0000, 4'd0,  1'b0, NO_RSP};
      stim_rows[9]  = '{OP_INSERT, 32'h0000_0001, 4'd0,  1'b0, NO_RSP};
      stim_rows[10] = '{OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1'b0, NO_RSP};
      stim_rows[11] = '{OP_INSERT, 32'hFFFF_FFFE, 4'd0,  1'b0, NO_RSP};
      stim_rows[12] = '{OP_INSERT, 32'h1234_5678, 4'd0,  1'b0, NO_RSP};
      stim_rows[13] = '{OP_INSERT, 32'h0000_0000, 4'd0,  1'b0, NO_RSP};
      stim_rows[14] = '{OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b0, NO_RSP};
      stim_rows[15] = '{OP_INSERT, 32'h8000_0001, 4'd0,  1'b0, NO_RSP};
      stim_rows[16] = '{OP_INSERT, 32'h5555_5555, 4'd0,  1'b0, NO_RSP};
      stim_rows[17] = '{OP_INSERT, 32'hAAAA_AAAA, 4'd0,  1'b0, NO_RSP};
      stim_rows[18] = '{OP_INSERT, 32'h0000_FFFF, 4'd0,  1'b0, NO_RSP};
      stim_rows[19] = '{OP_INSERT, 32'hFFFF_0000, 4'd0,  1'b0, NO_RSP};
      stim_rows[20] = '{OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1'b0, NO_RSP};
      stim_rows[21] = '{OP_INSERT, 32'h0F0F_0F0F, 4'd0,  1'b1, '{32'h0, ST_FULL, 5'd16}};
      stim_rows[22] = '{OP_LOOKUP, 32'h0000_0000, 4'd15, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd16}};
      stim_rows[23] = '{OP_REMOVE, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_OK, 5'd15}};
      stim_rows[24] = '{OP_REMOVE, 32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_OK, 5'd14}};
      stim_rows[25] = '{OP_NOP,    32'hFFFF_FFFF, 4'd15, 1'b1, '{32'h0, ST_OK, 5'd14}};

      // Hold reset, then release it
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < NUM_ROWS; i++) begin
         send_op(stim_rows[i].op, stim_rows[i].value, stim_rows[i].index,
                 stim_rows[i].typed, stim_rows[i].rsp);
      end

      // Random phases, each biased toward filling, draining or mixing
      done = 0;
      first_phase = 1'b1;
      while (done < RANDOM_OPS) begin
         // hold off until every outstanding response is back
         if (first_phase || $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_rsps.size() != 0);
            first_phase = 1'b0;
         end
         case ($urandom_range(0, 3))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = $urandom_range(30, 70);
         endcase
         no_idle   = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(40, 160);
         for (j = 0; j < phase_len && done < RANDOM_OPS; j++) begin
            if ($urandom_range(0, 99) < 3) op = OP_NOP;
            else if ($urandom_range(0, 99) < insert_pct) op = OP_INSERT;
            else if ($urandom_range(0, 1) == 1) op = OP_LOOKUP;
            else op = OP_REMOVE;
            case ($urandom_range(0, 9))
               0: v = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               1, 2: v = $urandom_range(0, 7);
               3: v = (shadow_count > 0) ? shadow_vals[$urandom_range(0, shadow_count - 1)]
                                         : $urandom;
               default: v = $urandom;
            endcase
            // mostly valid indexes, some past the count
            if (shadow_count > 0 && $urandom_range(0, 9) < 8) begin
               ix = 4'($urandom_range(0, shadow_count - 1));
            end else begin
               ix = 4'($urandom_range(0, 15));
            end
            send_op(op, v, ix, 1'b0, NO_RSP);
            if (op != OP_NOP) done++;
         end
      end

      // Drain outstanding responses, then watch for strays
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Response backpressure: random stalls with occasional quiet stretches
   initial begin
      int n;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 200)) @(negedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Compare each response transaction against the oldest expected one
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected response: read_value %h status %0d entry_count %0d",
                   rsp_tdata[READ_W-1:0], rsp_tuser, rsp_tdata[READ_W+COUNT_W-1:READ_W]);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_tdata[READ_W-1:0] !== want.read_value) begin
               $error("read_value: expected %h, actual %h",
                      want.read_value, rsp_tdata[READ_W-1:0]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[READ_W+COUNT_W-1:READ_W] !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_tdata[READ_W+COUNT_W-1:READ_W]);
               error_count++;
            end
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

// ----- sorted_array_table.f -----
rtl/sat_pkg.sv
rtl/sat_ram.sv
rtl/sat_datapath.sv
rtl/sat_controller.sv
rtl/sorted_array_table.sv
tb/sv/sorted_array_table_tb.sv
